// ===== rtl/bfcps_pkg.sv =====
`timescale 1ns / 1ps
// Shared codes, field widths and controller/datapath handshake structs
// for the best-first cell path search block. No dependencies.
package bfcps_pkg;

  // Widths of the request and result fields
  localparam int IDX_FIELD_W   = 6;
  localparam int SLOT_FIELD_W  = 2;
  localparam int CNT_FIELD_W   = 2;
  localparam int COORD_FIELD_W = 16;
  localparam int CFG_W         = 7;
  localparam int ACTION_W      = 2;
  localparam int STATUS_W      = 2;

  // Request actions
  localparam logic [ACTION_W-1:0] ACT_LOAD_CELL = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_NBR  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FIND_PATH = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_PATH_STEP = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_PATH   = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                load_cell;
    logic                load_nbr;
    logic                q_latch;
    logic                q_init;
    logic                rd_goal;
    logic                lat_start;
    logic                lat_goal;
    logic                exp_close;
    logic                cnt_latch;
    logic                nbr_rd;
    logic                nb_take;
    logic                slot_inc;
    logic                dist_init;
    logic                phase_next;
    logic                sq_step;
    logic                root_start;
    logic                root_add;
    logic                ins_init;
    logic                ins_rd;
    logic                ins_shift;
    logic                ins_write;
    logic                pop_rd;
    logic                pop;
    logic                walk_init;
    logic                walk_step;
    logic                walk_take;
    logic                em_rd;
    logic                emit;
    logic [STATUS_W-1:0] emit_code;
    logic                emit_last;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic reject;
    logic cnt_done;
    logic nb_oob;
    logic nb_goal;
    logic nb_new;
    logic sq_done;
    logic root_busy;
    logic phase;
    logic q_full;
    logic pos_zero;
    logic shift_more;
    logic q_empty;
    logic iter_last;
    logic walk_done;
    logic len_zero;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/bfcps_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results.
// Depends on bfcps_pkg for field widths.
interface bfcps_in_if;
  import bfcps_pkg::*;
  logic                            valid;
  logic                            ready;
  logic [ACTION_W-1:0]             action;
  logic [IDX_FIELD_W-1:0]          cell_index;
  logic signed [COORD_FIELD_W-1:0] center_x;
  logic signed [COORD_FIELD_W-1:0] center_y;
  logic signed [COORD_FIELD_W-1:0] center_z;
  logic [CNT_FIELD_W-1:0]          neighbor_count;
  logic [SLOT_FIELD_W-1:0]         neighbor_slot;
  logic [IDX_FIELD_W-1:0]          neighbor_cell;
  logic [IDX_FIELD_W-1:0]          start_cell;
  logic [IDX_FIELD_W-1:0]          goal_cell;

  modport source(output valid, action, cell_index, center_x, center_y, center_z,
                 neighbor_count, neighbor_slot, neighbor_cell, start_cell, goal_cell,
                 input ready);
  modport sink(input valid, action, cell_index, center_x, center_y, center_z,
               neighbor_count, neighbor_slot, neighbor_cell, start_cell, goal_cell,
               output ready);
endinterface

interface bfcps_out_if;
  import bfcps_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [IDX_FIELD_W-1:0] path_cell;
  logic [STATUS_W-1:0]    status;
  logic                   last;

  modport source(output valid, path_cell, status, last, input ready);
  modport sink(input valid, path_cell, status, last, output ready);
endinterface

// ===== rtl/bfcps_isqrt.sv =====
`timescale 1ns / 1ps
// Iterative integer square root (floor), one result bit per cycle.
// No package dependencies.
module bfcps_isqrt #(
  parameter int IN_W = 34
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [IN_W-1:0]       value,
  output logic                  busy,
  output logic [(IN_W+1)/2-1:0] root
);
  localparam int OUT_W  = (IN_W + 1) / 2;
  localparam int PAD_W  = 2 * OUT_W;
  localparam int STEP_W = $clog2(OUT_W + 1);

  logic [PAD_W-1:0]  rad_r;
  logic [OUT_W+1:0]  rem_r;
  logic [OUT_W-1:0]  root_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic [OUT_W+1:0]  rem_sh;
  logic [OUT_W+1:0]  trial;
  logic              fits;

  // bring down two radicand bits and try the next root bit
  assign rem_sh = {rem_r[OUT_W-1:0], rad_r[PAD_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign fits   = rem_sh >= trial;

  // step counter and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= STEP_W'(OUT_W);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) busy_r <= 1'b0;
    end
  end

  // radicand, remainder and partial root
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= PAD_W'(value);
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[PAD_W-3:0], 2'b00};
      rem_r  <= fits ? rem_sh - trial : rem_sh;
      root_r <= {root_r[OUT_W-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign root = root_r;
endmodule

// ===== rtl/bfcps_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: cell and neighbor memories, open/closed marks, sorted open
// queue, distance unit, path walk and result register. Uses bfcps_pkg, bfcps_isqrt.
module bfcps_datapath #(
  parameter int MAX_CELLS     = 64,
  parameter int MAX_NEIGHBORS = 3,
  parameter int COORD_BITS    = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  bfcps_pkg::dp_cmd_t                       cmd,
  output bfcps_pkg::dp_stat_t                      stat,
  input  logic                                     cfg_we,
  input  logic [bfcps_pkg::CFG_W-1:0]              cfg_wdata,
  input  logic [bfcps_pkg::IDX_FIELD_W-1:0]        in_cell_index,
  input  logic signed [bfcps_pkg::COORD_FIELD_W-1:0] in_center_x,
  input  logic signed [bfcps_pkg::COORD_FIELD_W-1:0] in_center_y,
  input  logic signed [bfcps_pkg::COORD_FIELD_W-1:0] in_center_z,
  input  logic [bfcps_pkg::CNT_FIELD_W-1:0]        in_neighbor_count,
  input  logic [bfcps_pkg::SLOT_FIELD_W-1:0]       in_neighbor_slot,
  input  logic [bfcps_pkg::IDX_FIELD_W-1:0]        in_neighbor_cell,
  input  logic [bfcps_pkg::IDX_FIELD_W-1:0]        in_start_cell,
  input  logic [bfcps_pkg::IDX_FIELD_W-1:0]        in_goal_cell,
  input  logic                                     out_ready,
  output logic                                     out_valid,
  output logic [bfcps_pkg::IDX_FIELD_W-1:0]        out_path_cell,
  output logic [bfcps_pkg::STATUS_W-1:0]           out_status,
  output logic                                     out_last
);
  import bfcps_pkg::*;

  localparam int IDX_W     = $clog2(MAX_CELLS);
  localparam int LEN_W     = $clog2(MAX_CELLS + 1);
  localparam int NBR_DEPTH = MAX_CELLS * MAX_NEIGHBORS;
  localparam int NA_W      = $clog2(NBR_DEPTH);
  localparam int CNT_W     = $clog2(MAX_NEIGHBORS + 1);
  localparam int SUM_W     = 2 * COORD_BITS + 2;
  localparam int ROOT_W    = COORD_BITS + 1;
  localparam int COST_W    = ROOT_W + 1;
  localparam int CELL_W    = 3 * COORD_BITS + CNT_W;
  localparam int QE_W      = COST_W + IDX_W;

  // ---------------------------------------------------------------- storage
  logic [CELL_W-1:0]      cell_mem [MAX_CELLS];
  logic [IDX_FIELD_W-1:0] nbr_mem  [NBR_DEPTH];
  logic [IDX_W-1:0]       pred_mem [MAX_CELLS];
  logic [IDX_W-1:0]       path_mem [MAX_CELLS];
  logic [QE_W-1:0]        q_mem    [MAX_CELLS];

  logic [CELL_W-1:0]      cell_rdata_r;
  logic [IDX_FIELD_W-1:0] nbr_rdata_r;
  logic [IDX_W-1:0]       pred_rdata_r;
  logic [IDX_W-1:0]       path_rdata_r;
  logic [QE_W-1:0]        q_rdata_r;

  logic [CFG_W-1:0]       cfg_count_r;
  logic [IDX_FIELD_W-1:0] start_f_r, goal_f_r;
  logic [IDX_W-1:0]       start_r, goal_r, cur_r, nb_r, walk_r, head_r;
  logic [MAX_CELLS-1:0]   open_r, closed_r;
  logic [CNT_W-1:0]       ncnt_r, slot_r;
  logic [LEN_W-1:0]       size_r, pos_r, iter_r, len_r;

  logic signed [COORD_BITS-1:0] sc_r [3];
  logic signed [COORD_BITS-1:0] gc_r [3];
  logic signed [COORD_BITS-1:0] rd_c [3];
  logic [CNT_W-1:0]             rd_cnt;

  logic [1:0]              axis_r;
  logic                    phase_r;
  logic [SUM_W-1:0]        acc_r;
  logic [2*COORD_BITS-1:0] sq_r;
  logic [COST_W-1:0]       cost_r;
  logic                    root_busy;
  logic [ROOT_W-1:0]       root;

  logic                    out_valid_r;
  logic [IDX_FIELD_W-1:0]  out_cell_r;
  logic [STATUS_W-1:0]     out_status_r;
  logic                    out_last_r;

  // ------------------------------------------------------------ load decode
  logic [31:0]            ci_wide, slot_wide, nw_addr, nr_addr;
  logic                   ci_ok, slot_ok;
  logic [IDX_W-1:0]       ci_idx;
  logic [COORD_BITS-1:0]  ld_x, ld_y, ld_z;
  logic [CNT_W-1:0]       ld_cnt;

  assign ci_wide   = 32'(in_cell_index);
  assign slot_wide = 32'(in_neighbor_slot);
  assign ci_ok     = ci_wide < 32'(MAX_CELLS);
  assign slot_ok   = slot_wide < 32'(MAX_NEIGHBORS);
  assign ci_idx    = ci_wide[IDX_W-1:0];
  assign nw_addr   = 32'(ci_idx) * 32'(MAX_NEIGHBORS) + slot_wide;
  assign nr_addr   = 32'(cur_r) * 32'(MAX_NEIGHBORS) + 32'(slot_r);

  // coordinates: low COORD_BITS of the zero-extended field, taken as signed
  always_comb begin
    logic [31:0] xw, yw, zw;
    xw     = 32'($unsigned(in_center_x));
    yw     = 32'($unsigned(in_center_y));
    zw     = 32'($unsigned(in_center_z));
    ld_x   = xw[COORD_BITS-1:0];
    ld_y   = yw[COORD_BITS-1:0];
    ld_z   = zw[COORD_BITS-1:0];
    ld_cnt = (32'(in_neighbor_count) > 32'(MAX_NEIGHBORS)) ? CNT_W'(MAX_NEIGHBORS)
                                                           : CNT_W'(in_neighbor_count);
  end

  // ------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) cfg_count_r <= '0;
    else if (cfg_we) cfg_count_r <= cfg_wdata;
  end

  // ---------------------------------------------------- neighbor decode
  logic [31:0]      nb_wide;
  logic [IDX_W-1:0] nb_idx;
  logic             nb_oob, nb_goal, nb_new;

  assign nb_wide = 32'(nbr_rdata_r);
  assign nb_idx  = nb_wide[IDX_W-1:0];
  assign nb_oob  = nb_wide >= 32'(MAX_CELLS);
  assign nb_goal = !nb_oob && (nb_idx == goal_r);
  assign nb_new  = !nb_oob && !nb_goal && !open_r[nb_idx] && !closed_r[nb_idx];

  // ---------------------------------------------------------- cell memory
  logic             cell_rd_en;
  logic [IDX_W-1:0] cell_raddr;

  always_comb begin
    cell_rd_en = cmd.q_init || cmd.rd_goal || cmd.exp_close || (cmd.nb_take && nb_new);
    if (cmd.q_init)         cell_raddr = start_r;
    else if (cmd.rd_goal)   cell_raddr = goal_r;
    else if (cmd.exp_close) cell_raddr = cur_r;
    else                    cell_raddr = nb_idx;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_cell && ci_ok) cell_mem[ci_idx] <= {ld_x, ld_y, ld_z, ld_cnt};
    if (cell_rd_en) cell_rdata_r <= cell_mem[cell_raddr];
  end

  assign rd_c[0] = cell_rdata_r[CELL_W-1 -: COORD_BITS];
  assign rd_c[1] = cell_rdata_r[CELL_W-1-COORD_BITS -: COORD_BITS];
  assign rd_c[2] = cell_rdata_r[CELL_W-1-2*COORD_BITS -: COORD_BITS];
  assign rd_cnt  = cell_rdata_r[CNT_W-1:0];

  // ------------------------------------------------------ neighbor table
  always_ff @(posedge clk) begin
    if (cmd.load_nbr && ci_ok && slot_ok) nbr_mem[nw_addr[NA_W-1:0]] <= in_neighbor_cell;
    if (cmd.nbr_rd) nbr_rdata_r <= nbr_mem[nr_addr[NA_W-1:0]];
  end

  // ------------------------------------------------- query endpoints
  always_ff @(posedge clk) begin
    logic [31:0] sw, gw;
    sw = 32'(in_start_cell);
    gw = 32'(in_goal_cell);
    if (cmd.q_latch) begin
      start_f_r <= in_start_cell;
      goal_f_r  <= in_goal_cell;
      start_r   <= sw[IDX_W-1:0];
      goal_r    <= gw[IDX_W-1:0];
    end
    if (cmd.lat_start) for (int k = 0; k < 3; k++) sc_r[k] <= rd_c[k];
    if (cmd.lat_goal)  for (int k = 0; k < 3; k++) gc_r[k] <= rd_c[k];
  end

  // ---------------------------------------- expansion cursor and slots
  always_ff @(posedge clk) begin
    if (cmd.q_init) cur_r <= start_r;
    else if (cmd.pop) cur_r <= q_rdata_r[IDX_W-1:0];
    if (cmd.cnt_latch) begin
      ncnt_r <= rd_cnt;
      slot_r <= '0;
    end else if (cmd.slot_inc) begin
      slot_r <= slot_r + 1'b1;
    end
    if (cmd.nb_take) nb_r <= nb_idx;
  end

  // open and closed marks, cleared at once for each query
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.q_init) begin
      open_r   <= '0;
      closed_r <= '0;
    end else begin
      if (cmd.exp_close) closed_r[cur_r] <= 1'b1;
      if (cmd.nb_take && nb_new) open_r[nb_idx] <= 1'b1;
    end
  end

  // ---------------------------------------------------- distance unit
  logic signed [COORD_BITS:0] diff;
  logic [COORD_BITS:0]        mag;
  logic [COORD_BITS-1:0]      mag_n;

  always_comb begin
    logic signed [COORD_BITS-1:0] tgt, pt;
    tgt = '0;
    pt  = '0;
    if (axis_r != 2'd3) begin
      tgt = phase_r ? gc_r[axis_r] : sc_r[axis_r];
      pt  = rd_c[axis_r];
    end
    diff  = (COORD_BITS+1)'(tgt) - (COORD_BITS+1)'(pt);
    mag   = diff[COORD_BITS] ? -diff : diff;
    mag_n = mag[COORD_BITS-1:0];
  end

  // square one axis a cycle; the sum takes in each square in the cycle after
  always_ff @(posedge clk) begin
    if (cmd.dist_init || cmd.phase_next) begin
      acc_r   <= '0;
      sq_r    <= '0;
      axis_r  <= '0;
      phase_r <= cmd.phase_next;
    end else if (cmd.sq_step) begin
      sq_r   <= mag_n * mag_n;
      acc_r  <= acc_r + SUM_W'(sq_r);
      axis_r <= axis_r + 1'b1;
    end
    if (cmd.dist_init) cost_r <= '0;
    else if (cmd.root_add) cost_r <= cost_r + COST_W'(root);
  end

  bfcps_isqrt #(.IN_W(SUM_W)) u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.root_start),
    .value (acc_r),
    .busy  (root_busy),
    .root  (root)
  );

  // ------------------------------------------------------- open queue
  function automatic logic [IDX_W-1:0] qphys(input logic [LEN_W-1:0] p);
    logic [31:0] s;
    s = 32'(head_r) + 32'(p);
    if (s >= 32'(MAX_CELLS)) s = s - 32'(MAX_CELLS);
    return s[IDX_W-1:0];
  endfunction

  logic [LEN_W-1:0] pos_m1;
  assign pos_m1 = pos_r - 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.ins_shift) q_mem[qphys(pos_r)] <= q_rdata_r;
    else if (cmd.ins_write) q_mem[qphys(pos_r)] <= {cost_r, nb_r};
    if (cmd.ins_rd) q_rdata_r <= q_mem[qphys(pos_m1)];
    else if (cmd.pop_rd) q_rdata_r <= q_mem[head_r];
  end

  // queue pointers and expansion count
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.q_init) begin
      head_r <= '0;
      size_r <= '0;
      iter_r <= '0;
    end else if (cmd.pop) begin
      head_r <= (head_r == IDX_W'(MAX_CELLS - 1)) ? '0 : head_r + 1'b1;
      size_r <= size_r - 1'b1;
      iter_r <= iter_r + 1'b1;
    end else if (cmd.ins_write) begin
      size_r <= size_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_init) pos_r <= size_r;
    else if (cmd.ins_shift) pos_r <= pos_m1;
  end

  // ------------------------------------------------ predecessors and walk
  logic [LEN_W-1:0] len_m1;
  assign len_m1 = len_r - 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.nb_take && (nb_goal || nb_new)) pred_mem[nb_idx] <= cur_r;
    if (cmd.walk_step) pred_rdata_r <= pred_mem[walk_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_step) path_mem[len_r[IDX_W-1:0]] <= walk_r;
    if (cmd.em_rd) path_rdata_r <= path_mem[len_m1[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      walk_r <= goal_r;
      len_r  <= '0;
    end else begin
      if (cmd.walk_take) walk_r <= pred_rdata_r;
      if (cmd.walk_step) len_r <= len_r + 1'b1;
      else if (cmd.em_rd) len_r <= len_m1;
    end
  end

  // ---------------------------------------------------- result register
  logic [31:0] path_wide;
  assign path_wide = 32'(path_rdata_r);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.emit) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_cell_r   <= (cmd.emit_code == ST_PATH_STEP) ? path_wide[IDX_FIELD_W-1:0] : '0;
      out_status_r <= cmd.emit_code;
      out_last_r   <= cmd.emit_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_path_cell = out_cell_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

  // ----------------------------------------------------------- status
  always_comb begin
    stat.reject     = (32'(start_f_r) >= 32'(cfg_count_r)) ||
                      (32'(goal_f_r) >= 32'(cfg_count_r)) ||
                      (32'(start_f_r) >= 32'(MAX_CELLS)) ||
                      (32'(goal_f_r) >= 32'(MAX_CELLS)) ||
                      (start_f_r == goal_f_r);
    stat.cnt_done   = slot_r >= ncnt_r;
    stat.nb_oob     = nb_oob;
    stat.nb_goal    = nb_goal;
    stat.nb_new     = nb_new;
    stat.sq_done    = axis_r == 2'd3;
    stat.root_busy  = root_busy;
    stat.phase      = phase_r;
    stat.q_full     = size_r == LEN_W'(MAX_CELLS);
    stat.pos_zero   = pos_r == '0;
    stat.shift_more = q_rdata_r[QE_W-1 -: COST_W] > cost_r;
    stat.q_empty    = size_r == '0;
    stat.iter_last  = iter_r == LEN_W'(MAX_CELLS - 1);
    stat.walk_done  = (walk_r == start_r) || (len_r == LEN_W'(MAX_CELLS));
    stat.len_zero   = len_r == '0;
    stat.out_free   = !out_valid_r || out_ready;
  end
endmodule

// ===== rtl/bfcps_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: sequences loads, query check, expansion,
// distance and queue insertion, path walk and result emission. Uses bfcps_pkg.
module bfcps_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [bfcps_pkg::ACTION_W-1:0] in_action,
  output logic                           in_ready,
  output bfcps_pkg::dp_cmd_t             cmd,
  input  bfcps_pkg::dp_stat_t            stat
);
  import bfcps_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_RD_GOAL, S_LAT_GOAL, S_EXP, S_CNT, S_SLOT, S_NB_CHK,
    S_DIST, S_SQ, S_ROOT, S_ROOT_WAIT, S_INS_RD, S_INS_CMP, S_INS_WR,
    S_NEXT, S_POP, S_WALK, S_W_RD, S_EM_RD, S_EM_OUT, S_REJ, S_NOPATH
  } state_t;

  state_t state_r, state_nxt;
  logic   acc;

  assign in_ready = state_r == S_IDLE;
  assign acc      = in_valid && in_ready;

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_action)
            ACT_LOAD_CELL: cmd.load_cell = 1'b1;
            ACT_LOAD_NBR:  cmd.load_nbr  = 1'b1;
            ACT_FIND_PATH: begin
              cmd.q_latch = 1'b1;
              state_nxt   = S_CHECK;
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        if (stat.reject) state_nxt = S_REJ;
        else begin
          cmd.q_init = 1'b1;
          state_nxt  = S_RD_GOAL;
        end
      end
      S_RD_GOAL: begin
        cmd.lat_start = 1'b1;
        cmd.rd_goal   = 1'b1;
        state_nxt     = S_LAT_GOAL;
      end
      S_LAT_GOAL: begin
        cmd.lat_goal = 1'b1;
        state_nxt    = S_EXP;
      end
      S_EXP: begin
        cmd.exp_close = 1'b1;
        state_nxt     = S_CNT;
      end
      S_CNT: begin
        cmd.cnt_latch = 1'b1;
        state_nxt     = S_SLOT;
      end
      S_SLOT: begin
        if (stat.cnt_done) state_nxt = S_NEXT;
        else begin
          cmd.nbr_rd = 1'b1;
          state_nxt  = S_NB_CHK;
        end
      end
      // goal ends the search; new cells go to the distance unit
      S_NB_CHK: begin
        cmd.nb_take = 1'b1;
        if (stat.nb_oob) begin
          cmd.slot_inc = 1'b1;
          state_nxt    = S_SLOT;
        end else if (stat.nb_goal) begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WALK;
        end else if (stat.nb_new) begin
          state_nxt = S_DIST;
        end else begin
          cmd.slot_inc = 1'b1;
          state_nxt    = S_SLOT;
        end
      end
      S_DIST: begin
        cmd.dist_init = 1'b1;
        state_nxt     = S_SQ;
      end
      S_SQ: begin
        cmd.sq_step = 1'b1;
        if (stat.sq_done) state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_start = 1'b1;
        state_nxt      = S_ROOT_WAIT;
      end
      S_ROOT_WAIT: begin
        if (!stat.root_busy) begin
          cmd.root_add = 1'b1;
          if (stat.phase) begin
            cmd.ins_init = 1'b1;
            state_nxt    = S_INS_RD;
          end else begin
            cmd.phase_next = 1'b1;
            state_nxt      = S_SQ;
          end
        end
      end
      // insertion sort from the tail: shift entries of higher cost back
      S_INS_RD: begin
        if (stat.q_full) begin
          cmd.slot_inc = 1'b1;
          state_nxt    = S_SLOT;
        end else if (stat.pos_zero) begin
          state_nxt = S_INS_WR;
        end else begin
          cmd.ins_rd = 1'b1;
          state_nxt  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (stat.shift_more) begin
          cmd.ins_shift = 1'b1;
          state_nxt     = S_INS_RD;
        end else begin
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.ins_write = 1'b1;
        cmd.slot_inc  = 1'b1;
        state_nxt     = S_SLOT;
      end
      S_NEXT: begin
        if (stat.q_empty) state_nxt = S_NOPATH;
        else begin
          cmd.pop_rd = 1'b1;
          state_nxt  = S_POP;
        end
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = stat.iter_last ? S_NOPATH : S_EXP;
      end
      // follow predecessors from the goal back to the start
      S_WALK: begin
        if (stat.walk_done) state_nxt = S_EM_RD;
        else begin
          cmd.walk_step = 1'b1;
          state_nxt     = S_W_RD;
        end
      end
      S_W_RD: begin
        cmd.walk_take = 1'b1;
        state_nxt     = S_WALK;
      end
      S_EM_RD: begin
        cmd.em_rd = 1'b1;
        state_nxt = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_code = ST_PATH_STEP;
          cmd.emit_last = stat.len_zero;
          state_nxt     = stat.len_zero ? S_IDLE : S_EM_RD;
        end
      end
      S_REJ: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_code = ST_REJECTED;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_NOPATH: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_code = ST_NO_PATH;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

// ===== rtl/best_first_cell_path_search_top.sv =====
`timescale 1ns / 1ps
// Top level of the best-first cell path search block: request and result
// channels, configuration port, controller and datapath. Uses bfcps_pkg and bfcps_ifs.
//
// Load requests (cell center and neighbor count, or one neighbor slot) are
// taken in the idle state. A path request is checked first; a rejected
// query returns one result. Otherwise the search closes a cell (expand,
// latch its neighbor count) and reads each neighbor slot; a newly opened
// cell gets its two distances, each computed by a serial square root (one
// root bit per cycle), and is inserted into the ordered open queue with a
// read and a compare per entry shifted. Popping the queue is a read and a
// pop step. A found path is walked back cell by cell from the goal, then
// emitted cell by cell. The open and closed marks are cleared at once at
// the start of each query that passes the check, so there is no clearing pass.
// A new request is taken only when the previous query has handed its last
// result to the output register; that result may still wait there.
module best_first_cell_path_search_top #(
  parameter int MAX_CELLS     = 64,
  parameter int MAX_NEIGHBORS = 3,
  parameter int COORD_BITS    = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bfcps_in_if.sink                      in_chan,
  bfcps_out_if.source                   out_chan,
  input  logic                          cfg_we,
  input  logic [bfcps_pkg::CFG_W-1:0]   cfg_wdata
);
  import bfcps_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign in_chan.ready = in_ready;

  // sequencer
  bfcps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_action (in_chan.action),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // storage and arithmetic
  bfcps_datapath #(
    .MAX_CELLS     (MAX_CELLS),
    .MAX_NEIGHBORS (MAX_NEIGHBORS),
    .COORD_BITS    (COORD_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_cell_index     (in_chan.cell_index),
    .in_center_x       (in_chan.center_x),
    .in_center_y       (in_chan.center_y),
    .in_center_z       (in_chan.center_z),
    .in_neighbor_count (in_chan.neighbor_count),
    .in_neighbor_slot  (in_chan.neighbor_slot),
    .in_neighbor_cell  (in_chan.neighbor_cell),
    .in_start_cell     (in_chan.start_cell),
    .in_goal_cell      (in_chan.goal_cell),
    .out_ready         (out_chan.ready),
    .out_valid         (out_chan.valid),
    .out_path_cell     (out_chan.path_cell),
    .out_status        (out_chan.status),
    .out_last          (out_chan.last)
  );

  // a path request closes the request side until its last result is in the output register
  a_find_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_ready && in_chan.action == ACT_FIND_PATH |=> !in_ready)
    else $error("request taken during a query");

  // rejected and no-path results are always the final one
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.status != ST_PATH_STEP |-> out_chan.last)
    else $error("error result without last");

  // the square root unit is never busy while requests are taken
  a_root_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !stat.root_busy)
    else $error("square root busy while idle");

  // a result is only written into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("result overwritten");
endmodule
